// ===== rtl/core/rdc_pkg.sv =====
// rdc_pkg: shared constants, register indexes and sequencer states for the
// radix digit converter core and its checker.
// No dependencies.
package rdc_pkg;

  // Default data width of one beat
  localparam int VALUE_BITS_DEF = 31;

  // Configuration port geometry
  localparam int RADIX_W   = 4;
  localparam int CFG_IDX_W = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RADIX     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'b1;

  // Reset values and radix clamp limits
  localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd2;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd10;
  localparam logic [RADIX_W-1:0] DECIMAL     = 4'd10;

  // Direction codes
  localparam logic DIR_TO_DIGITS = 1'b0;
  localparam logic DIR_TO_BINARY = 1'b1;

  // Dividend bits consumed per divider cycle
  localparam int CHUNK = 8;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACC,
    ST_OUT
  } rdc_state_t;

endpackage

// ===== rtl/core/radix_digit_converter.sv =====
// radix_digit_converter: top level, a small sequencer around one shared
// digit divider and one multiply-accumulate step.
// Depends on rdc_pkg.
//
// Converts one value per beat between binary and digit form (decimal digits
// standing for base-radix digits); direction 0 splits the value into base
// radix digits and weights them by powers of ten, direction 1 splits it into
// decimal digits and weights them by powers of the radix. Radix is clamped to
// 2..10. A true result above 2^VALUE_BITS-1 returns all ones with overflow set.
// The block takes one beat at a time: in_ready is low from acceptance until the
// result has been moved to the output register, which frees the input side
// while the result waits for out_ready. For each source digit, the divider
// extracts the digit in one pass over the dividend, eight dividend bits per
// cycle, and the accumulate state then weights and accumulates it; a zero
// value goes straight to the output state. Conversion stops early once
// overflow is seen. Configuration writes are taken at any edge; the mode
// is latched when a beat is accepted, so a write applies from the next beat.
module radix_digit_converter
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [RADIX_W-1:0]    cfg_wdata,
  // input beat
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  // result beat
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] out_converted,
  output logic                  out_overflow
);

  localparam int PADW   = ((VALUE_BITS + CHUNK - 1) / CHUNK) * CHUNK;
  localparam int CHUNKS = PADW / CHUNK;
  localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int PW     = VALUE_BITS + RADIX_W;

  // configuration registers
  logic [RADIX_W-1:0] radix_r;
  logic               direction_r;

  // sequencer and datapath registers
  rdc_state_t          state_r, state_nxt;
  logic [PADW-1:0]       work_r, work_nxt;
  logic [RADIX_W-1:0]    rem_r, rem_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [RADIX_W-1:0]    src_r, src_nxt;
  logic [RADIX_W-1:0]    dst_r, dst_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [VALUE_BITS-1:0] wgt_r, wgt_nxt;
  logic                  wbig_r, wbig_nxt;
  logic                  ovf_r, ovf_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_conv_r, out_conv_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  // datapath intermediates
  logic [RADIX_W-1:0]    radix_k;
  logic [RADIX_W-1:0]    div_rem;
  logic [RADIX_W:0]      div_t;
  logic [CHUNK-1:0]      div_q;
  logic [PW-1:0]         prod_d;
  logic [PW-1:0]         prod_w;
  logic [VALUE_BITS:0]   acc_sum;
  logic                  ovf_acc;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= RADIX_RESET;
      direction_r <= DIR_TO_DIGITS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIX:     radix_r     <= cfg_wdata;
        REG_DIRECTION: direction_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // radix clamped to the supported range
  always_comb begin
    if (radix_r < RADIX_MIN) begin
      radix_k = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      radix_k = RADIX_MAX;
    end else begin
      radix_k = radix_r;
    end
  end

  // shared divider: eight restoring steps on the small remainder per cycle
  always_comb begin
    div_rem = rem_r;
    div_t   = '0;
    div_q   = '0;
    for (int i = 0; i < CHUNK; i++) begin
      div_t = {div_rem, work_r[PADW-1-i]};
      if (div_t >= {1'b0, src_r}) begin
        div_rem          = RADIX_W'(div_t - {1'b0, src_r});
        div_q[CHUNK-1-i] = 1'b1;
      end else begin
        div_rem = div_t[RADIX_W-1:0];
      end
    end
  end

  // digit weighting: digit times weight, weight times target base
  assign prod_d  = PW'(rem_r) * PW'(wgt_r);
  assign prod_w  = PW'(dst_r) * PW'(wgt_r);
  assign acc_sum = (VALUE_BITS+1)'(acc_r) + (VALUE_BITS+1)'(prod_d[VALUE_BITS-1:0]);

  // sequencer next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    acc_nxt       = acc_r;
    wgt_nxt       = wgt_r;
    wbig_nxt      = wbig_r;
    ovf_nxt       = ovf_r;
    ovf_acc       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_conv_nxt  = out_conv_r;
    out_ovf_nxt   = out_ovf_r;
    in_ready      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          work_nxt = PADW'(in_value);
          rem_nxt  = '0;
          cnt_nxt  = '0;
          acc_nxt  = '0;
          wgt_nxt  = VALUE_BITS'(1);
          wbig_nxt = 1'b0;
          ovf_nxt  = 1'b0;
          if (direction_r == DIR_TO_DIGITS) begin
            src_nxt = radix_k;
            dst_nxt = DECIMAL;
          end else begin
            src_nxt = DECIMAL;
            dst_nxt = radix_k;
          end
          state_nxt = (in_value == '0) ? ST_OUT : ST_DIV;
        end
      end

      // one chunk of the dividend per cycle; quotient shifts in at the bottom
      ST_DIV: begin
        work_nxt = (work_r << CHUNK) | PADW'(div_q);
        rem_nxt  = div_rem;
        cnt_nxt  = cnt_r + CW'(1);
        if (cnt_r == CW'(CHUNKS - 1)) begin
          state_nxt = ST_ACC;
        end
      end

      // rem_r holds the digit, work_r the quotient
      ST_ACC: begin
        if (rem_r != '0 && !ovf_r) begin
          if (wbig_r || prod_d[PW-1:VALUE_BITS] != '0 || acc_sum[VALUE_BITS]) begin
            ovf_acc = 1'b1;
          end else begin
            acc_nxt = acc_sum[VALUE_BITS-1:0];
          end
        end
        ovf_nxt = ovf_acc;
        if (!wbig_r) begin
          if (prod_w[PW-1:VALUE_BITS] != '0) begin
            wbig_nxt = 1'b1;
          end else begin
            wgt_nxt = prod_w[VALUE_BITS-1:0];
          end
        end
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = (work_r == '0 || ovf_acc) ? ST_OUT : ST_DIV;
      end

      // hand the result to the output register once it is free
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_conv_nxt  = ovf_r ? '1 : acc_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    acc_r      <= acc_nxt;
    wgt_r      <= wgt_nxt;
    wbig_r     <= wbig_nxt;
    ovf_r      <= ovf_nxt;
    out_conv_r <= out_conv_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_converted = out_conv_r;
  assign out_overflow  = out_ovf_r;

endmodule

// ===== rtl/core/rdc_checker.sv =====
// rdc_checker: port-level assertions for radix_digit_converter, with the
// bind that attaches it. Depends on rdc_pkg and radix_digit_converter.
module rdc_checker
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [VALUE_BITS-1:0] out_converted,
  input logic                  out_overflow
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_converted) && $stable(out_overflow))
    else $error("result beat changed while stalled");

  // an overflowed result is saturated
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_converted == '1)
    else $error("overflow without saturated result");

  // one beat at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a beat is in progress");

  // reset empties the output register
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind radix_digit_converter rdc_checker #(.VALUE_BITS(VALUE_BITS)) u_rdc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_converted (out_converted),
  .out_overflow  (out_overflow)
);
